[src/qmeu_pkg.sv]
`default_nettype none
package qmeu_pkg;
	localparam int QueueDepthDef = 1024;
	localparam int ProgramDepthDef = 4096;
	localparam int NumRegsDef = 26;
	localparam int ValueW = 16;
	localparam int OpW = 5;
	localparam int RegIdxW = 5;
	localparam int PcW = 12;

	typedef enum logic [OpW-1:0] {
		OP_PUSH_IMM = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
		OP_DIV = 5'd4, OP_MOD = 5'd5, OP_POP_REG = 5'd6, OP_PUSH_REG = 5'd7,
		OP_PRINT_POP = 5'd8, OP_PRINT_REG = 5'd9, OP_CHAR_POP = 5'd10,
		OP_CHAR_REG = 5'd11, OP_LABEL = 5'd12, OP_JUMP = 5'd13, OP_JZ = 5'd14,
		OP_JEQ = 5'd15, OP_JGT = 5'd16, OP_QUIT = 5'd17
	} op_t;

	// decoded instruction handed from front to back
	typedef struct packed {
		logic [OpW-1:0] op;
		logic [RegIdxW-1:0] r1;
		logic [RegIdxW-1:0] r2;
		logic [ValueW-1:0] imm;
		logic [PcW-1:0] target;
		logic pops2;
		logic pops1;
		logic pushes;
	} decoded_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_POP_X, ST_WAIT_X, ST_POP_Y, ST_WAIT_Y,
		ST_MUL, ST_DIV, ST_EXEC, ST_OUT
	} state_t;
endpackage
`default_nettype wire

[src/qmeu_in_if.sv]
`default_nettype none
interface qmeu_in_if;
	logic valid;
	logic ready;
	logic [4:0] operation;
	logic [4:0] reg_first;
	logic [4:0] reg_second;
	logic [15:0] immediate;
	logic [11:0] jump_target;
	modport source(output valid, operation, reg_first, reg_second, immediate, jump_target,
		input ready);
	modport sink(input valid, operation, reg_first, reg_second, immediate, jump_target,
		output ready);
endinterface
`default_nettype wire

[src/qmeu_out_if.sv]
`default_nettype none
interface qmeu_out_if;
	logic valid;
	logic ready;
	logic [11:0] next_pc;
	logic print_valid;
	logic print_is_char;
	logic [15:0] print_value;
	logic halted;
	logic underflow;
	logic overflow;
	modport source(output valid, next_pc, print_valid, print_is_char, print_value, halted,
		underflow, overflow, input ready);
	modport sink(input valid, next_pc, print_valid, print_is_char, print_value, halted,
		underflow, overflow, output ready);
endinterface
`default_nettype wire

[src/qmeu_ram.sv]
`default_nettype none
module qmeu_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[src/qmeu_front.sv]
`default_nettype none
module qmeu_front import qmeu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	qmeu_in_if.sink in_ch,
	output logic dq_valid,
	input wire logic dq_pop,
	output decoded_t dq_data
);
	// two-entry queue of decoded requests
	decoded_t buf_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	decoded_t d;
	logic push;

	always_comb begin
		d.op = in_ch.operation;
		d.r1 = in_ch.reg_first;
		d.r2 = in_ch.reg_second;
		d.imm = in_ch.immediate;
		d.target = in_ch.jump_target;
		d.pops2 = (in_ch.operation == OP_ADD) || (in_ch.operation == OP_SUB)
			|| (in_ch.operation == OP_MUL) || (in_ch.operation == OP_DIV)
			|| (in_ch.operation == OP_MOD);
		d.pops1 = (in_ch.operation == OP_POP_REG) || (in_ch.operation == OP_PRINT_POP)
			|| (in_ch.operation == OP_CHAR_POP);
		d.pushes = d.pops2 || (in_ch.operation == OP_PUSH_IMM)
			|| (in_ch.operation == OP_PUSH_REG);
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign dq_valid = (cnt_q != 2'd0);
	assign dq_data = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (dq_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, dq_pop};
		end
	end
endmodule
`default_nettype wire

[src/qmeu_back.sv]
`default_nettype none
module qmeu_back import qmeu_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef,
	parameter int ProgramDepth = ProgramDepthDef,
	parameter int NumRegs = NumRegsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic dq_valid,
	output logic dq_pop,
	input wire decoded_t dq_data,
	qmeu_out_if.source out_ch
);
	localparam int QaW = $clog2(QueueDepth);
	localparam int QcW = $clog2(QueueDepth + 1);
	localparam int PaW = $clog2(ProgramDepth);

	state_t state_q, state_d;
	decoded_t ins_q;
	logic [QaW-1:0] head_q, tail_q;
	logic [QcW-1:0] count_q;
	logic [ValueW-1:0] regs_q [NumRegs];
	logic [PaW-1:0] pc_q;
	logic halt_q;
	logic [ValueW-1:0] x_q, y_q, res_q, rem_q;
	logic [4:0] step_q;
	logic under_q;
	logic ram_we;
	logic [ValueW-1:0] ram_rd, ram_wd;
	logic [ValueW-1:0] rv1, rv2;
	logic [2*ValueW-1:0] prod;
	logic [ValueW:0] trial;
	logic [ValueW-1:0] rem_sh;

	// out register
	logic ov_q, pv_q, pc_q_char, hl_q, uf_q, of_q;
	logic [11:0] npc_q;
	logic [ValueW-1:0] pval_q;

	qmeu_ram #(.Width(ValueW), .Depth(QueueDepth)) u_ram (
		.clk(clk), .we(ram_we), .waddr(tail_q), .wdata(ram_wd),
		.raddr(head_q), .rdata(ram_rd));

	assign rv1 = (ins_q.r1 < RegIdxW'(NumRegs)) ? regs_q[ins_q.r1[$clog2(NumRegs)-1:0]] : '0;
	assign rv2 = (ins_q.r2 < RegIdxW'(NumRegs)) ? regs_q[ins_q.r2[$clog2(NumRegs)-1:0]] : '0;
	assign prod = x_q * y_q;
	assign rem_sh = {rem_q[ValueW-2:0], x_q[ValueW-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, y_q};

	always_comb begin
		unique case (ins_q.op)
			OP_PUSH_IMM: ram_wd = ins_q.imm;
			OP_PUSH_REG: ram_wd = rv1;
			default: ram_wd = res_q;
		endcase
	end
	assign ram_we = (state_q == ST_EXEC) && !halt_q && ins_q.pushes
		&& (count_q != QcW'(QueueDepth));

	assign dq_pop = (state_q == ST_IDLE) && dq_valid && !ov_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (dq_pop) state_d = ST_POP_X;
			ST_POP_X: state_d = (halt_q || !(ins_q.pops1 || ins_q.pops2)) ? ST_EXEC : ST_WAIT_X;
			ST_WAIT_X: state_d = ins_q.pops2 ? ST_POP_Y : ST_EXEC;
			ST_POP_Y: state_d = ST_WAIT_Y;
			ST_WAIT_Y: begin
				if (ins_q.op == OP_MUL) state_d = ST_MUL;
				else if (ins_q.op == OP_DIV || ins_q.op == OP_MOD) state_d = ST_DIV;
				else state_d = ST_EXEC;
			end
			ST_MUL: state_d = ST_EXEC;
			ST_DIV: if (step_q == 5'd15) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dq_pop) ins_q <= dq_data;
		if (state_q == ST_WAIT_X) x_q <= (count_q == '0) ? '0 : ram_rd;
		if (state_q == ST_WAIT_Y) begin
			y_q <= (count_q == '0) ? '0 : ram_rd;
			rem_q <= '0;
			step_q <= '0;
			unique case (ins_q.op)
				OP_ADD: res_q <= x_q + ((count_q == '0) ? '0 : ram_rd);
				OP_SUB: res_q <= x_q - ((count_q == '0) ? '0 : ram_rd);
				default: res_q <= '0;
			endcase
		end
		if (state_q == ST_MUL) res_q <= prod[ValueW-1:0];
		if (state_q == ST_DIV) begin
			step_q <= step_q + 5'd1;
			x_q <= {x_q[ValueW-2:0], ~trial[ValueW]};
			rem_q <= trial[ValueW] ? rem_sh : trial[ValueW-1:0];
			if (step_q == 5'd15) begin
				if (y_q == '0) res_q <= '0;
				else if (ins_q.op == OP_DIV) res_q <= {x_q[ValueW-2:0], ~trial[ValueW]};
				else res_q <= trial[ValueW] ? rem_sh : trial[ValueW-1:0];
			end
		end
		if (state_q == ST_EXEC) begin
			pv_q <= 1'b0;
			pc_q_char <= 1'b0;
			pval_q <= '0;
			if (!halt_q) begin
				unique case (ins_q.op)
					OP_PRINT_POP: begin pv_q <= 1'b1; pval_q <= x_q; end
					OP_PRINT_REG: begin pv_q <= 1'b1; pval_q <= rv1; end
					OP_CHAR_POP: begin pv_q <= 1'b1; pc_q_char <= 1'b1;
						pval_q <= {8'd0, x_q[7:0]}; end
					OP_CHAR_REG: begin pv_q <= 1'b1; pc_q_char <= 1'b1;
						pval_q <= {8'd0, rv1[7:0]}; end
					default: ;
				endcase
			end
		end
	end

	logic [PaW-1:0] next_pc;
	logic [PaW-1:0] tgt;
	assign tgt = PaW'(ins_q.target);
	always_comb begin
		next_pc = pc_q + PaW'(1);
		if (halt_q) next_pc = pc_q;
		else begin
			unique case (ins_q.op)
				OP_JUMP: next_pc = tgt;
				OP_JZ: if (rv1 == '0) next_pc = tgt;
				OP_JEQ: if (rv1 == rv2) next_pc = tgt;
				OP_JGT: if (rv1 > rv2) next_pc = tgt;
				OP_QUIT: next_pc = pc_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0; tail_q <= '0; count_q <= '0;
			pc_q <= '0; halt_q <= 1'b0; under_q <= 1'b0; ov_q <= 1'b0;
			hl_q <= 1'b0; uf_q <= 1'b0; of_q <= 1'b0; npc_q <= '0;
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			if (state_q == ST_IDLE) under_q <= 1'b0;
			if ((state_q == ST_POP_X || state_q == ST_POP_Y) && !halt_q
				&& (ins_q.pops1 || ins_q.pops2)) begin
				// read issued this cycle at head; advance after read
				if (count_q == '0) under_q <= 1'b1;
			end
			if ((state_q == ST_WAIT_X || state_q == ST_WAIT_Y) && count_q != '0) begin
				head_q <= (head_q == QaW'(QueueDepth - 1)) ? '0 : head_q + QaW'(1);
				count_q <= count_q - QcW'(1);
			end
			if (state_q == ST_EXEC) begin
				if (ram_we) begin
					tail_q <= (tail_q == QaW'(QueueDepth - 1)) ? '0 : tail_q + QaW'(1);
					count_q <= count_q + QcW'(1);
				end
				if (!halt_q && ins_q.op == OP_POP_REG && ins_q.r1 < RegIdxW'(NumRegs))
					regs_q[ins_q.r1[$clog2(NumRegs)-1:0]] <= x_q;
				pc_q <= next_pc;
				if (!halt_q && ins_q.op == OP_QUIT) halt_q <= 1'b1;
				hl_q <= halt_q || (ins_q.op == OP_QUIT);
				uf_q <= under_q && !halt_q;
				of_q <= !halt_q && ins_q.pushes && (count_q == QcW'(QueueDepth));
				npc_q <= 12'(next_pc);
				ov_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.next_pc = npc_q;
	assign out_ch.print_valid = pv_q;
	assign out_ch.print_is_char = pc_q_char;
	assign out_ch.print_value = pval_q;
	assign out_ch.halted = hl_q;
	assign out_ch.underflow = uf_q;
	assign out_ch.overflow = of_q;
endmodule
`default_nettype wire

[src/queue_machine_execute_unit_top.sv]
`default_nettype none
// Queue machine execute unit: one decoded instruction per request, one result per request.
// The front buffers up to two requests; the back runs one at a time: it pops the first
// operand if there is one, then the second for add/sub/mul/div/mod, then multiplies for
// mul or divides for div/mod (one quotient bit per cycle), then executes; the next request
// is taken once the result is accepted. The operand queue is a single-port-read RAM and
// its two pops are serialized. Registers and pc reset to zero; queue data is not cleared.
module queue_machine_execute_unit_top import qmeu_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef,
	parameter int ProgramDepth = ProgramDepthDef,
	parameter int NumRegs = NumRegsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	qmeu_in_if.sink in_ch,
	qmeu_out_if.source out_ch
);
	logic dq_valid, dq_pop;
	decoded_t dq_data;

	qmeu_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.dq_valid(dq_valid), .dq_pop(dq_pop), .dq_data(dq_data));

	qmeu_back #(.QueueDepth(QueueDepth), .ProgramDepth(ProgramDepth), .NumRegs(NumRegs)) u_back (
		.clk(clk), .arst_n(arst_n), .dq_valid(dq_valid), .dq_pop(dq_pop),
		.dq_data(dq_data), .out_ch(out_ch));
endmodule
`default_nettype wire
